// ===== sv/drc_pkg.sv =====
// Shared types and constants for the residency statistics core.
package drc_pkg;

    localparam int LEVELS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    localparam logic [3:0] KIND_LVL_TIME  = 4'd0;
    localparam logic [3:0] KIND_LVL_CNT   = 4'd1;
    localparam logic [3:0] KIND_LVL_STAMP = 4'd2;
    localparam logic [3:0] KIND_TRANS     = 4'd3;
    localparam logic [3:0] KIND_ON_TIME   = 4'd4;
    localparam logic [3:0] KIND_ON_CNT    = 4'd5;
    localparam logic [3:0] KIND_ON_STAMP  = 4'd6;
    localparam logic [3:0] KIND_OFF_TIME  = 4'd7;
    localparam logic [3:0] KIND_OFF_CNT   = 4'd8;
    localparam logic [3:0] KIND_OFF_STAMP = 4'd9;

endpackage

// ===== sv/dvfs_residency_counters_core.sv =====
// Top level of the level and power residency statistics core.
// Input channel (in_valid/in_ready) takes one beat per event: action 0 starts
// tracking, action 1 reports a level or power change, action 2 reads one
// statistic, action 3 is ignored. Output channel (out_valid/out_ready) returns
// one beat, read_data, for each read and nothing for other actions.
// Each accepted beat first reads the statistics memories, then in execute
// modifies and writes back. The next beat is taken in the cycle after the
// write, so a read always sees the preceding update. A read result reaches
// read_data through the output register, which is loaded in execute.
// The result sits in an output register; while it is still full a new read
// waits in execute with in_ready low until the receiver takes the result.
// Beats other than reads pass while the register is full.
// After reset the core zeroes the transition table and the per-level tables
// in one pass over the LEVELS*LEVELS entries, with in_ready low; the power
// totals clear at once. Time sums wrap at 64 bits, counts at 32 bits.
module dvfs_residency_counters_core
    import drc_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [63:0] evt_ts,
    input  logic [3:0]  lvl_from,
    input  logic [3:0]  lvl_to,
    input  logic        power_on,
    input  logic [3:0]  read_kind,
    input  logic [3:0]  read_row,
    input  logic [3:0]  read_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data
);

    localparam int LW  = $clog2(LEVELS);
    localparam int TD  = LEVELS * LEVELS;
    localparam int TW  = $clog2(TD);
    localparam int CW  = TW + 1;

    state_t state_reg, state_next;

    logic [CW-1:0] clr_reg;
    logic          clearing;

    logic [1:0]  act_reg;
    logic [63:0] time_reg;
    logic [63:0] delta_reg;
    logic [3:0]  old_reg, new_reg, kind_reg, row_reg, col_reg;
    logic        pwr_reg;

    logic [63:0] on_time_reg, off_time_reg, on_stamp_reg, off_stamp_reg;
    logic [31:0] on_cnt_reg, off_cnt_reg;
    logic [63:0] prev_time_reg;
    logic        prev_on_reg;
    logic [3:0]  prev_level_reg;

    logic        out_valid_reg;
    logic [63:0] read_data_reg;

    logic [1:0] cur_act;
    logic [3:0] cur_old, cur_new, cur_row, cur_col;

    logic [LW-1:0] time_raddr, cnt_raddr, stamp_raddr;
    logic [TW-1:0] trans_raddr;
    logic [63:0]   time_rdata, stamp_rdata;
    logic [31:0]   cnt_rdata, trans_rdata;

    logic          time_we, cnt_we, stamp_we, trans_we;
    logic [LW-1:0] time_waddr, lvl_waddr;
    logic [TW-1:0] trans_waddr;
    logic [63:0]   time_wdata, stamp_wdata;
    logic [31:0]   cnt_wdata, trans_wdata;

    logic old_ok, new_ok, row_ok, col_ok;
    logic exec_start, exec_update, exec_read, do_enter, load_out;
    logic [63:0] read_value;

    assign clearing = (state_reg == S_CLEAR);
    assign in_ready = (state_reg == S_IDLE);

    // Address sources: ports while idle, captured beat afterwards.
    assign cur_act = (state_reg == S_IDLE) ? action   : act_reg;
    assign cur_old = (state_reg == S_IDLE) ? lvl_from : old_reg;
    assign cur_new = (state_reg == S_IDLE) ? lvl_to   : new_reg;
    assign cur_row = (state_reg == S_IDLE) ? read_row : row_reg;
    assign cur_col = (state_reg == S_IDLE) ? read_col : col_reg;

    assign time_raddr  = (cur_act == ACT_READ) ? LW'(cur_row) : LW'(cur_old);
    assign cnt_raddr   = (cur_act == ACT_READ) ? LW'(cur_row) : LW'(cur_new);
    assign stamp_raddr = LW'(cur_row);
    assign trans_raddr = (cur_act == ACT_READ)
        ? TW'(TW'(cur_row) * TW'(LEVELS) + TW'(cur_col))
        : TW'(TW'(cur_old) * TW'(LEVELS) + TW'(cur_new));

    assign old_ok = (32'(old_reg) < LEVELS);
    assign new_ok = (32'(new_reg) < LEVELS);
    assign row_ok = (32'(row_reg) < LEVELS);
    assign col_ok = (32'(col_reg) < LEVELS);

    assign exec_start  = (state_reg == S_EXEC) && (act_reg == ACT_START);
    assign exec_update = (state_reg == S_EXEC) && (act_reg == ACT_UPDATE);
    assign exec_read   = (state_reg == S_EXEC) && (act_reg == ACT_READ);

    assign do_enter = exec_start
        || (exec_update && prev_on_reg && pwr_reg && (old_reg != new_reg))
        || (exec_update && !prev_on_reg && pwr_reg && (prev_level_reg != new_reg));

    // Write ports: clearing pass, else read-modify-write of the beat.
    always_comb
    begin
        time_waddr  = LW'(old_reg);
        lvl_waddr   = LW'(new_reg);
        trans_waddr = TW'(TW'(old_reg) * TW'(LEVELS) + TW'(new_reg));
        time_wdata  = time_rdata + delta_reg;
        cnt_wdata   = cnt_rdata + 32'd1;
        stamp_wdata = time_reg;
        trans_wdata = trans_rdata + 32'd1;
        time_we     = exec_update && prev_on_reg && old_ok;
        cnt_we      = do_enter && new_ok;
        stamp_we    = do_enter && new_ok;
        trans_we    = do_enter && !exec_start && old_ok && new_ok;
        if (clearing)
        begin
            time_waddr  = LW'(clr_reg);
            lvl_waddr   = LW'(clr_reg);
            trans_waddr = clr_reg[TW-1:0];
            time_wdata  = '0;
            cnt_wdata   = '0;
            stamp_wdata = '0;
            trans_wdata = '0;
            time_we     = (32'(clr_reg) < LEVELS);
            cnt_we      = (32'(clr_reg) < LEVELS);
            stamp_we    = (32'(clr_reg) < LEVELS);
            trans_we    = 1'b1;
        end
    end

    drc_ram #(.WIDTH(64), .DEPTH(LEVELS)) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (time_waddr),
        .wdata (time_wdata),
        .raddr (time_raddr),
        .rdata (time_rdata)
    );

    drc_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (lvl_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    drc_ram #(.WIDTH(64), .DEPTH(LEVELS)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (lvl_waddr),
        .wdata (stamp_wdata),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    drc_ram #(.WIDTH(32), .DEPTH(TD)) u_trans_ram (
        .clk   (clk),
        .we    (trans_we),
        .waddr (trans_waddr),
        .wdata (trans_wdata),
        .raddr (trans_raddr),
        .rdata (trans_rdata)
    );

    always_comb
    begin
        case (kind_reg)
            KIND_LVL_TIME:  read_value = row_ok ? time_rdata : 64'd0;
            KIND_LVL_CNT:   read_value = row_ok ? {32'd0, cnt_rdata} : 64'd0;
            KIND_LVL_STAMP: read_value = row_ok ? stamp_rdata : 64'd0;
            KIND_TRANS:     read_value = (row_ok && col_ok) ? {32'd0, trans_rdata} : 64'd0;
            KIND_ON_TIME:   read_value = on_time_reg;
            KIND_ON_CNT:    read_value = {32'd0, on_cnt_reg};
            KIND_ON_STAMP:  read_value = on_stamp_reg;
            KIND_OFF_TIME:  read_value = off_time_reg;
            KIND_OFF_CNT:   read_value = {32'd0, off_cnt_reg};
            KIND_OFF_STAMP: read_value = off_stamp_reg;
            default:        read_value = 64'd0;
        endcase
    end

    assign load_out = exec_read && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == TD - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!exec_read || load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
        end
    end

    // Capture the beat and the interval since the last event.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= action;
            time_reg  <= evt_ts;
            delta_reg <= evt_ts - prev_time_reg;
            old_reg   <= lvl_from;
            new_reg   <= lvl_to;
            pwr_reg   <= power_on;
            kind_reg  <= read_kind;
            row_reg   <= read_row;
            col_reg   <= read_col;
        end
        if (load_out)
        begin
            read_data_reg <= read_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg    <= '0;
            off_time_reg   <= '0;
            on_stamp_reg   <= '0;
            off_stamp_reg  <= '0;
            on_cnt_reg     <= '0;
            off_cnt_reg    <= '0;
            prev_time_reg  <= '0;
            prev_on_reg    <= 1'b0;
            prev_level_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (exec_start)
            begin
                prev_time_reg <= time_reg;
                prev_on_reg   <= pwr_reg;
            end
            if (exec_update)
            begin
                if (prev_on_reg)
                begin
                    on_time_reg <= on_time_reg + delta_reg;
                    if (!pwr_reg)
                    begin
                        off_cnt_reg   <= off_cnt_reg + 32'd1;
                        off_stamp_reg <= time_reg;
                    end
                end
                else
                begin
                    off_time_reg <= off_time_reg + delta_reg;
                    if (pwr_reg)
                    begin
                        on_cnt_reg   <= on_cnt_reg + 32'd1;
                        on_stamp_reg <= time_reg;
                    end
                end
                prev_time_reg  <= time_reg;
                prev_on_reg    <= pwr_reg;
                prev_level_reg <= new_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat did not enter execute");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(exec_read))
        else $error("result raised without a read beat");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |=> !clearing)
        else $error("clearing pass restarted");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(time_we || cnt_we || stamp_we || trans_we))
        else $error("memory write outside execute or clear");
`endif

endmodule

// ===== sv/drc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module drc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/tb_residency_checker.sv =====
// Checker for the residency statistics core: tracks the statistics and compares every read beat.
`timescale 1ns / 100ps

module tb_residency_checker
    import drc_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [63:0] evt_ts,
    input  logic [3:0]  lvl_from,
    input  logic [3:0]  lvl_to,
    input  logic        power_on,
    input  logic [3:0]  read_kind,
    input  logic [3:0]  read_row,
    input  logic [3:0]  read_col,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] read_data,
    output int          errors,
    output int          pending,
    output int          reads_checked
);

    logic [63:0] lvl_time    [LEVELS];
    logic [31:0] lvl_entries [LEVELS];
    logic [63:0] lvl_stamp   [LEVELS];
    logic [31:0] trans_cnt   [LEVELS][LEVELS];
    logic [63:0] on_time;
    logic [31:0] on_entries;
    logic [63:0] on_stamp;
    logic [63:0] off_time;
    logic [31:0] off_entries;
    logic [63:0] off_stamp;
    logic [63:0] prior_ts;
    logic        last_on;
    logic [3:0]  prior_lvl;

    logic [63:0] read_queue [$];
    logic [63:0] oldest_read;

    initial
    begin
        errors        = 0;
        pending       = 0;
        reads_checked = 0;
    end

    task automatic clear_stats();
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_time[i]    = '0;
            lvl_entries[i] = '0;
            lvl_stamp[i]   = '0;
            for (int j = 0; j < LEVELS; j++)
            begin
                trans_cnt[i][j] = '0;
            end
        end
        on_time     = '0;
        on_entries  = '0;
        on_stamp    = '0;
        off_time    = '0;
        off_entries = '0;
        off_stamp   = '0;
        prior_ts    = '0;
        last_on     = 1'b0;
        prior_lvl   = '0;
    endtask

    task automatic note_level_entry(input logic [3:0] lvl, input logic [63:0] t);
        if (lvl < LEVELS)
        begin
            lvl_entries[lvl] += 32'd1;
            lvl_stamp[lvl]    = t;
        end
    endtask

    task automatic bump_transition(input logic [3:0] src, input logic [3:0] dst);
        if (src < LEVELS && dst < LEVELS)
        begin
            trans_cnt[src][dst] += 32'd1;
        end
    endtask

    task automatic apply_update(input logic [63:0] t, input logic [3:0] oldl,
                                input logic [3:0] newl, input logic pwr);
        logic [63:0] span;
        span = t - prior_ts;
        if (last_on)
        begin
            if (pwr)
            begin
                if (oldl != newl)
                begin
                    note_level_entry(newl, t);
                    bump_transition(oldl, newl);
                end
            end
            else
            begin
                off_entries += 32'd1;
                off_stamp    = t;
            end
            if (oldl < LEVELS)
            begin
                lvl_time[oldl] += span;
            end
            on_time += span;
        end
        else
        begin
            if (pwr)
            begin
                on_entries += 32'd1;
                on_stamp    = t;
                if (prior_lvl != newl)
                begin
                    note_level_entry(newl, t);
                    bump_transition(oldl, newl);
                end
            end
            off_time += span;
        end
        last_on   = pwr;
        prior_ts  = t;
        prior_lvl = newl;
    endtask

    function automatic logic [63:0] lookup_stat(input logic [3:0] k, input logic [3:0] r,
                                                input logic [3:0] c);
        logic row_ok;
        row_ok = (r < LEVELS);
        case (k)
            KIND_LVL_TIME:  return row_ok ? lvl_time[r] : 64'd0;
            KIND_LVL_CNT:   return row_ok ? {32'd0, lvl_entries[r]} : 64'd0;
            KIND_LVL_STAMP: return row_ok ? lvl_stamp[r] : 64'd0;
            KIND_TRANS:     return (row_ok && c < LEVELS) ? {32'd0, trans_cnt[r][c]} : 64'd0;
            KIND_ON_TIME:   return on_time;
            KIND_ON_CNT:    return {32'd0, on_entries};
            KIND_ON_STAMP:  return on_stamp;
            KIND_OFF_TIME:  return off_time;
            KIND_OFF_CNT:   return {32'd0, off_entries};
            KIND_OFF_STAMP: return off_stamp;
            default:        return 64'd0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_stats();
            read_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                case (action)
                    ACT_START:
                    begin
                        prior_ts = evt_ts;
                        last_on  = power_on;
                        note_level_entry(lvl_to, evt_ts);
                    end
                    ACT_UPDATE: apply_update(evt_ts, lvl_from, lvl_to, power_on);
                    ACT_READ:   read_queue.push_back(lookup_stat(read_kind, read_row, read_col));
                    default:    ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (read_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: read_data beat with no read outstanding: expected none, got %h",
                             $time, read_data);
                end
                else
                begin
                    oldest_read = read_queue.pop_front();
                    reads_checked++;
                    if (read_data !== oldest_read)
                    begin
                        errors++;
                        $display("%0t: read_data mismatch: expected %h, got %h",
                                 $time, oldest_read, read_data);
                    end
                end
            end
        end
        pending <= read_queue.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the residency statistics core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import drc_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [3:0]  KIND_UNUSED = 4'd15;
    localparam logic [3:0]  TOP_LEVEL   = 4'd15;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  action     = ACT_NOP;
    logic [63:0] evt_ts     = '0;
    logic [3:0]  lvl_from   = '0;
    logic [3:0]  lvl_to     = '0;
    logic        power_on   = 1'b0;
    logic [3:0]  read_kind  = '0;
    logic [3:0]  read_row   = '0;
    logic [3:0]  read_col   = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [63:0] read_data;

    int errors;
    int pending;
    int reads_checked;

    int          cycle_count    = 0;
    int          stall_pct      = 0;
    int          hold_go        = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          sender_gap_pct = 0;
    int          beats_sent     = 0;
    logic [63:0] stim_time      = '0;
    logic [3:0]  stim_level     = '0;

    dvfs_residency_counters_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .evt_ts     (evt_ts),
        .lvl_from   (lvl_from),
        .lvl_to     (lvl_to),
        .power_on   (power_on),
        .read_kind  (read_kind),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data)
    );

    tb_residency_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .evt_ts        (evt_ts),
        .lvl_from      (lvl_from),
        .lvl_to        (lvl_to),
        .power_on      (power_on),
        .read_kind     (read_kind),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .errors        (errors),
        .pending       (pending),
        .reads_checked (reads_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d reads outstanding", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_beat(input logic [1:0] a, input logic [63:0] t, input logic [3:0] ol,
                             input logic [3:0] nl, input logic p, input logic [3:0] k,
                             input logic [3:0] r, input logic [3:0] c);
        in_valid  <= 1'b1;
        action    <= a;
        evt_ts    <= t;
        lvl_from  <= ol;
        lvl_to    <= nl;
        power_on  <= p;
        read_kind <= k;
        read_row  <= r;
        read_col  <= c;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic send_update(input logic [63:0] t, input logic [3:0] ol, input logic [3:0] nl,
                               input logic p);
        send_beat(ACT_UPDATE, t, ol, nl, p, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)));
    endtask

    task automatic send_read(input logic [3:0] k, input logic [3:0] r, input logic [3:0] c);
        send_beat(ACT_READ, {$urandom, $urandom}, 4'($urandom_range(15)),
                  4'($urandom_range(15)), 1'($urandom_range(1)), k, r, c);
    endtask

    task automatic idle_gap();
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_random_item();
        int          roll;
        logic [1:0]  act;
        logic [63:0] t;
        logic [3:0]  ol;
        logic [3:0]  nl;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            act = 2'($urandom_range(3));
            t   = {$urandom, $urandom};
            nl  = 4'($urandom_range(15));
            send_beat(act, t, 4'($urandom_range(15)), nl, 1'($urandom_range(1)),
                      4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
            if (act == ACT_UPDATE)
            begin
                stim_level = nl;
            end
            if (act == ACT_UPDATE || act == ACT_START)
            begin
                stim_time = t;
            end
        end
        else if (roll < 15)
        begin
            t = stim_time + 64'($urandom_range(1, 1000));
            send_beat(ACT_START, t, 4'($urandom_range(15)), 4'($urandom_range(15)),
                      1'($urandom_range(1)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                      4'($urandom_range(15)));
            stim_time = t;
        end
        else if (roll < 55)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_read(4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
            end
            else
            begin
                send_read(4'($urandom_range(9)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
            end
        end
        else
        begin
            t  = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                           : stim_time + 64'($urandom_range(1, 100000));
            ol = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : stim_level;
            nl = ($urandom_range(4) < 2) ? stim_level : 4'($urandom_range(15));
            send_update(t, ol, nl, $urandom_range(3) != 0);
            stim_time  = t;
            stim_level = nl;
        end
    endtask

    task automatic run_phase(input int count, input int gap_pct, input int stall);
        stall_pct      <= stall;
        sender_gap_pct  = gap_pct;
        repeat (count)
        begin
            idle_gap();
            offer_random_item();
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(ACT_START, 64'd100, 4'd0, 4'd3, 1'b1, KIND_LVL_TIME, 4'd0, 4'd0);
        send_update(64'd250, 4'd3, 4'd3, 1'b1);
        send_update(64'd400, 4'd3, 4'd7, 1'b1);
        send_update(64'd1000, 4'd7, 4'd7, 1'b0);
        send_update(64'd1500, 4'd7, 4'd7, 1'b0);
        send_update(64'd2000, 4'd7, 4'd7, 1'b1);
        send_update(64'd2600, 4'd7, 4'd0, 1'b0);
        send_update(64'd3000, 4'd0, TOP_LEVEL, 1'b1);
        send_update(64'hFFFF_FFFF_FFFF_FFF0, TOP_LEVEL, TOP_LEVEL, 1'b1);
        send_update(64'h0000_0000_0000_0010, TOP_LEVEL, 4'd0, 1'b1);
        send_beat(ACT_NOP, {$urandom, $urandom}, TOP_LEVEL, TOP_LEVEL, 1'b1, KIND_ON_TIME,
                  TOP_LEVEL, TOP_LEVEL);
        send_read(KIND_LVL_TIME, 4'd3, 4'd0);
        send_read(KIND_LVL_CNT, 4'd7, 4'd0);
        send_read(KIND_LVL_STAMP, TOP_LEVEL, 4'd0);
        send_read(KIND_TRANS, 4'd3, 4'd7);
        send_read(KIND_ON_TIME, 4'd0, 4'd0);
        send_read(KIND_ON_CNT, 4'd0, 4'd0);
        send_read(KIND_ON_STAMP, 4'd0, 4'd0);
        send_read(KIND_OFF_TIME, 4'd0, 4'd0);
        send_read(KIND_OFF_CNT, 4'd0, 4'd0);
        send_read(KIND_OFF_STAMP, 4'd0, 4'd0);
        send_read(KIND_TRANS, TOP_LEVEL, 4'd0);
        send_read(KIND_TRANS, 4'd0, TOP_LEVEL);
        send_read(KIND_UNUSED, TOP_LEVEL, TOP_LEVEL);
        send_beat(ACT_START, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, TOP_LEVEL, 1'b0, KIND_LVL_TIME,
                  4'd0, 4'd0);
        send_read(KIND_LVL_TIME, 4'd0, 4'd0);
        drain();

        stim_time  = 64'hFFFF_FFFF_FFFF_FFFF;
        stim_level = 4'd0;

        run_phase(125, 0, 0);
        run_phase(125, 83, 0);
        run_phase(125, 0, 83);
        run_phase(125, 29, 29);

        stall_pct     <= 0;
        hold_go       <= hold_go + 1;
        sender_gap_pct = 0;
        repeat (30)
        begin
            send_read(4'($urandom_range(9)), 4'($urandom_range(15)), 4'($urandom_range(15)));
        end
        drain();

        repeat (20) @(posedge clk);
        $display("Sent %0d beats and checked %0d reads across free-running, sender-idle,",
                 beats_sent, reads_checked);
        $display("receiver-stall, mixed, back-pressure and drain phases.");
        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
